>>> design/isrb_pkg.sv
package isrb_pkg;

    localparam int RAW_W     = 16;
    localparam int TRIG_W    = 18;
    localparam int SCALE_W   = 24;
    localparam int HALF_W    = SCALE_W / 2;
    localparam int FRAC_W    = 16;
    localparam int OUT_W     = 32;
    localparam int STAMP_W   = 32;
    localparam int PROD_W    = RAW_W + TRIG_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int MAG_W     = PROD_W;
    localparam int PART_W    = MAG_W + HALF_W;
    localparam int ACC_W     = PART_W + 1;
    localparam int RND_W     = ACC_W - HALF_W;
    localparam int SGN_W     = RND_W + 1;
    localparam int DIF_W     = SGN_W + 1;
    localparam int N_VEC     = 3;
    localparam int N_AX      = 3;
    localparam int HI_VEC    = 1;
    localparam int N_STAGE   = 6;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 32;

    localparam logic [SCALE_W-1:0] LOW_G_SCALE_RST  = SCALE_W'(80336);
    localparam logic [SCALE_W-1:0] HIGH_G_SCALE_RST = SCALE_W'(1285377);
    localparam logic [SCALE_W-1:0] GYRO_SCALE_RST   = SCALE_W'(2048000);
    localparam logic signed [TRIG_W-1:0] ROT_COS_RST = TRIG_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_G_SCALE  = 4'd0,
        CFG_HIGH_G_SCALE = 4'd1,
        CFG_GYRO_SCALE   = 4'd2,
        CFG_ROT_COS      = 4'd3,
        CFG_ROT_SIN      = 4'd4,
        CFG_BIAS_X       = 4'd5,
        CFG_BIAS_Y       = 4'd6,
        CFG_BIAS_Z       = 4'd7
    } t_cfg_index;

    typedef struct packed {
        logic [STAMP_W-1:0]      stamp;
        logic signed [RAW_W-1:0] lo_raw_x;
        logic signed [RAW_W-1:0] lo_raw_y;
        logic signed [RAW_W-1:0] lo_raw_z;
        logic signed [RAW_W-1:0] hi_raw_x;
        logic signed [RAW_W-1:0] hi_raw_y;
        logic signed [RAW_W-1:0] hi_raw_z;
        logic signed [RAW_W-1:0] rate_raw_x;
        logic signed [RAW_W-1:0] rate_raw_y;
        logic signed [RAW_W-1:0] rate_raw_z;
    } t_sample;

    typedef struct packed {
        logic [STAMP_W-1:0]      stamp_out;
        logic signed [OUT_W-1:0] lo_acc_x;
        logic signed [OUT_W-1:0] lo_acc_y;
        logic signed [OUT_W-1:0] lo_acc_z;
        logic signed [OUT_W-1:0] hi_acc_x;
        logic signed [OUT_W-1:0] hi_acc_y;
        logic signed [OUT_W-1:0] hi_acc_z;
        logic signed [OUT_W-1:0] rate_x;
        logic signed [OUT_W-1:0] rate_y;
        logic signed [OUT_W-1:0] rate_z;
    } t_result;

endpackage

>>> design/imu_scale_rotate_bias.sv
// Converts one IMU sample (low-g accel, high-g accel and gyro counts plus a
// timestamp) into board-frame Q16.16 values.
// Input channel: a sample beat is taken at a rising edge where start is high
// and busy is low. Busy never rises, so one beat can be taken every cycle.
// Output channel: o_valid is high for exactly one cycle with o_result, once
// the sample has passed through the register stages. Results leave in the
// order their samples arrived.
// There are six register stages: the rotation multipliers, the
// rotation sum and magnitude, the two 12-bit halves of the scale multiply,
// the rounding add, the sign restore, and the bias subtract with saturation.
// Configuration channel: a register is written at an edge where i_cfg_valid
// and o_cfg_ready are high; o_cfg_ready is always high. Indexes above seven
// are ignored. Write registers only while no sample is in flight.
// Reset clears all in-flight beats and returns every register to its
// default. The receiver cannot stall the output, so no result is held back.
module imu_scale_rotate_bias
    import isrb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_sample              i_sample,
    output logic                 o_valid,
    output t_result              o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic [SCALE_W-1:0]       r_scale [N_VEC];
    logic signed [TRIG_W-1:0] r_cos;
    logic signed [TRIG_W-1:0] r_sin;
    logic signed [OUT_W-1:0]  r_bias [N_AX];

    logic [N_STAGE-1:0]       r_vld;
    logic [STAMP_W-1:0]       r_stamp [N_STAGE];

    logic signed [RAW_W-1:0]  w_raw [N_VEC][N_AX];

    logic signed [PROD_W-1:0] r_xc [N_VEC];
    logic signed [PROD_W-1:0] r_ys [N_VEC];
    logic signed [PROD_W-1:0] r_xs [N_VEC];
    logic signed [PROD_W-1:0] r_yc [N_VEC];
    logic signed [RAW_W-1:0]  r_z  [N_VEC];

    logic [MAG_W-1:0]         n_mag  [N_VEC][N_AX];
    logic                     n_neg  [N_VEC][N_AX];
    logic [MAG_W-1:0]         r_mag  [N_VEC][N_AX];
    logic                     r_neg2 [N_VEC][N_AX];

    logic [PART_W-1:0]        r_pa   [N_VEC][N_AX];
    logic [PART_W-1:0]        r_pb   [N_VEC][N_AX];
    logic                     r_neg3 [N_VEC][N_AX];

    logic [RND_W-1:0]         n_rnd  [N_VEC][N_AX];
    logic [RND_W-1:0]         r_rnd  [N_VEC][N_AX];
    logic                     r_neg4 [N_VEC][N_AX];

    logic signed [SGN_W-1:0]  n_sgn  [N_VEC][N_AX];
    logic signed [SGN_W-1:0]  r_sgn  [N_VEC][N_AX];

    logic signed [OUT_W-1:0]  n_out  [N_VEC][N_AX];
    logic signed [OUT_W-1:0]  r_out  [N_VEC][N_AX];

    logic                     w_accept;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;

    assign w_raw[0][0] = i_sample.lo_raw_x;
    assign w_raw[0][1] = i_sample.lo_raw_y;
    assign w_raw[0][2] = i_sample.lo_raw_z;
    assign w_raw[1][0] = i_sample.hi_raw_x;
    assign w_raw[1][1] = i_sample.hi_raw_y;
    assign w_raw[1][2] = i_sample.hi_raw_z;
    assign w_raw[2][0] = i_sample.rate_raw_x;
    assign w_raw[2][1] = i_sample.rate_raw_y;
    assign w_raw[2][2] = i_sample.rate_raw_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_scale[0] <= LOW_G_SCALE_RST;
            r_scale[1] <= HIGH_G_SCALE_RST;
            r_scale[2] <= GYRO_SCALE_RST;
            r_cos      <= ROT_COS_RST;
            r_sin      <= '0;
            r_bias[0]  <= '0;
            r_bias[1]  <= '0;
            r_bias[2]  <= '0;
        end else begin
            r_vld <= {r_vld[N_STAGE-2:0], w_accept};
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LOW_G_SCALE:  r_scale[0] <= i_cfg_data[SCALE_W-1:0];
                    CFG_HIGH_G_SCALE: r_scale[1] <= i_cfg_data[SCALE_W-1:0];
                    CFG_GYRO_SCALE:   r_scale[2] <= i_cfg_data[SCALE_W-1:0];
                    CFG_ROT_COS:      r_cos      <= i_cfg_data[TRIG_W-1:0];
                    CFG_ROT_SIN:      r_sin      <= i_cfg_data[TRIG_W-1:0];
                    CFG_BIAS_X:       r_bias[0]  <= i_cfg_data[OUT_W-1:0];
                    CFG_BIAS_Y:       r_bias[1]  <= i_cfg_data[OUT_W-1:0];
                    CFG_BIAS_Z:       r_bias[2]  <= i_cfg_data[OUT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        logic signed [SUM_W-1:0] t [N_AX];
        for (int v = 0; v < N_VEC; v++) begin
            t[0] = SUM_W'(r_xc[v]) - SUM_W'(r_ys[v]);
            t[1] = SUM_W'(r_xs[v]) + SUM_W'(r_yc[v]);
            t[2] = {{(SUM_W - RAW_W - FRAC_W){r_z[v][RAW_W-1]}}, r_z[v], {FRAC_W{1'b0}}};
            for (int a = 0; a < N_AX; a++) begin
                n_neg[v][a] = t[a][SUM_W-1];
                n_mag[v][a] = t[a][SUM_W-1] ? MAG_W'(-t[a]) : MAG_W'(t[a]);
            end
        end
    end

    always_comb begin
        logic [ACC_W-1:0] acc;
        logic signed [DIF_W-1:0] dif;
        logic signed [DIF_W-1:0] bias;
        for (int v = 0; v < N_VEC; v++) begin
            for (int a = 0; a < N_AX; a++) begin
                acc = ACC_W'(r_pa[v][a]) + ACC_W'(r_pb[v][a] >> HALF_W)
                    + (ACC_W'(1) << (HALF_W - 1));
                n_rnd[v][a] = acc[ACC_W-1:HALF_W];
                n_sgn[v][a] = r_neg4[v][a] ? -SGN_W'(r_rnd[v][a]) : SGN_W'(r_rnd[v][a]);
                bias = (v == HI_VEC) ? DIF_W'(r_bias[a]) : '0;
                dif  = DIF_W'(r_sgn[v][a]) - bias;
                if (dif[DIF_W-1:OUT_W-1] == '0 || dif[DIF_W-1:OUT_W-1] == '1) begin
                    n_out[v][a] = dif[OUT_W-1:0];
                end else if (dif[DIF_W-1]) begin
                    n_out[v][a] = {1'b1, {(OUT_W - 1){1'b0}}};
                end else begin
                    n_out[v][a] = {1'b0, {(OUT_W - 1){1'b1}}};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_stamp[0] <= i_sample.stamp;
        for (int s = 1; s < N_STAGE; s++) begin
            r_stamp[s] <= r_stamp[s-1];
        end
        for (int v = 0; v < N_VEC; v++) begin
            r_xc[v] <= PROD_W'(w_raw[v][0]) * PROD_W'(r_cos);
            r_ys[v] <= PROD_W'(w_raw[v][1]) * PROD_W'(r_sin);
            r_xs[v] <= PROD_W'(w_raw[v][0]) * PROD_W'(r_sin);
            r_yc[v] <= PROD_W'(w_raw[v][1]) * PROD_W'(r_cos);
            r_z[v]  <= w_raw[v][2];
            for (int a = 0; a < N_AX; a++) begin
                r_mag[v][a]  <= n_mag[v][a];
                r_neg2[v][a] <= n_neg[v][a];
                r_pa[v][a]   <= PART_W'(r_mag[v][a])
                              * PART_W'(r_scale[v][SCALE_W-1:HALF_W]);
                r_pb[v][a]   <= PART_W'(r_mag[v][a])
                              * PART_W'(r_scale[v][HALF_W-1:0]);
                r_neg3[v][a] <= r_neg2[v][a];
                r_rnd[v][a]  <= n_rnd[v][a];
                r_neg4[v][a] <= r_neg3[v][a];
                r_sgn[v][a]  <= n_sgn[v][a];
                r_out[v][a]  <= n_out[v][a];
            end
        end
    end

    assign o_valid            = r_vld[N_STAGE-1];
    assign o_result.stamp_out = r_stamp[N_STAGE-1];
    assign o_result.lo_acc_x  = r_out[0][0];
    assign o_result.lo_acc_y  = r_out[0][1];
    assign o_result.lo_acc_z  = r_out[0][2];
    assign o_result.hi_acc_x  = r_out[1][0];
    assign o_result.hi_acc_y  = r_out[1][1];
    assign o_result.hi_acc_z  = r_out[1][2];
    assign o_result.rate_x    = r_out[2][0];
    assign o_result.rate_y    = r_out[2][1];
    assign o_result.rate_z    = r_out[2][2];

endmodule

>>> design/isrb_checker.sv
module isrb_checker
    import isrb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  t_sample              i_sample,
    input  logic                 o_valid,
    input  t_result              o_result
);

    // Every accepted beat is later presented to the receiver as a result.
    a_accept_to_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##6 o_valid)
        else $error("accepted beat did not produce a result");

    a_valid_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 6))
        else $error("result without an accepted beat");

    a_stamp_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.stamp_out == $past(i_sample.stamp, 6))
        else $error("timestamp does not match its beat");

    a_zero_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_sample.lo_raw_z, 6) == '0 |-> o_result.lo_acc_z == '0)
        else $error("zero low-g Z counts gave a nonzero result");

endmodule

bind imu_scale_rotate_bias isrb_checker u_isrb_checker (.*);

>>> test/isrb_result_checker.sv
`timescale 1ns / 1ps

module isrb_result_checker
    import isrb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  t_sample              i_sample,
    input  logic                 i_valid,
    input  t_result              i_result,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output int                   o_pending,
    output int                   o_errors
);

    localparam longint OUT_MAX = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint OUT_MIN = -(longint'(1) << (OUT_W - 1));

    logic [SCALE_W-1:0]       low_g_gain;
    logic [SCALE_W-1:0]       high_g_gain;
    logic [SCALE_W-1:0]       gyro_gain;
    logic signed [TRIG_W-1:0] cos_q;
    logic signed [TRIG_W-1:0] sin_q;
    logic signed [OUT_W-1:0]  offset_x;
    logic signed [OUT_W-1:0]  offset_y;
    logic signed [OUT_W-1:0]  offset_z;
    t_result                  board_queue [$];
    int                       mismatches = 0;

    // The product carries 40 fraction bits; one rounding to 16, ties away from zero.
    function automatic longint scaled_round(longint t, logic [SCALE_W-1:0] gain);
        longint unsigned mag;
        longint unsigned q;
        mag = (t < 0) ? -t : t;
        q = (mag * 64'(gain) + (64'd1 << (SCALE_W - 1))) >> SCALE_W;
        return (t < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [OUT_W-1:0] saturate(longint v);
        if (v > OUT_MAX) begin
            return OUT_W'(OUT_MAX);
        end
        if (v < OUT_MIN) begin
            return OUT_W'(OUT_MIN);
        end
        return OUT_W'(v);
    endfunction

    function automatic void board_vector(
        input  logic signed [RAW_W-1:0] x, y, z,
        input  logic [SCALE_W-1:0]      gain,
        output longint                  bx, by, bz
    );
        longint sx;
        longint sy;
        longint sz;
        longint c;
        longint s;
        sx = x;
        sy = y;
        sz = z;
        c = cos_q;
        s = sin_q;
        bx = scaled_round(sx * c - sy * s, gain);
        by = scaled_round(sx * s + sy * c, gain);
        bz = scaled_round(sz * (longint'(1) << FRAC_W), gain);
    endfunction

    function automatic t_result board_sample(t_sample s);
        longint  lx, ly, lz;
        longint  hx, hy, hz;
        longint  gx, gy, gz;
        t_result r;
        board_vector(s.lo_raw_x, s.lo_raw_y, s.lo_raw_z, low_g_gain, lx, ly, lz);
        board_vector(s.hi_raw_x, s.hi_raw_y, s.hi_raw_z, high_g_gain, hx, hy, hz);
        board_vector(s.rate_raw_x, s.rate_raw_y, s.rate_raw_z, gyro_gain, gx, gy, gz);
        r.stamp_out = s.stamp;
        r.lo_acc_x  = saturate(lx);
        r.lo_acc_y  = saturate(ly);
        r.lo_acc_z  = saturate(lz);
        r.hi_acc_x  = saturate(hx - offset_x);
        r.hi_acc_y  = saturate(hy - offset_y);
        r.hi_acc_z  = saturate(hz - offset_z);
        r.rate_x    = saturate(gx);
        r.rate_y    = saturate(gy);
        r.rate_z    = saturate(gz);
        return r;
    endfunction

    function automatic void check_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_board_sample(t_result want, t_result got);
        check_field("stamp_out", want.stamp_out, got.stamp_out);
        check_field("lo_acc_x", want.lo_acc_x, got.lo_acc_x);
        check_field("lo_acc_y", want.lo_acc_y, got.lo_acc_y);
        check_field("lo_acc_z", want.lo_acc_z, got.lo_acc_z);
        check_field("hi_acc_x", want.hi_acc_x, got.hi_acc_x);
        check_field("hi_acc_y", want.hi_acc_y, got.hi_acc_y);
        check_field("hi_acc_z", want.hi_acc_z, got.hi_acc_z);
        check_field("rate_x", want.rate_x, got.rate_x);
        check_field("rate_y", want.rate_y, got.rate_y);
        check_field("rate_z", want.rate_z, got.rate_z);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            low_g_gain  = LOW_G_SCALE_RST;
            high_g_gain = HIGH_G_SCALE_RST;
            gyro_gain   = GYRO_SCALE_RST;
            cos_q       = ROT_COS_RST;
            sin_q       = '0;
            offset_x    = '0;
            offset_y    = '0;
            offset_z    = '0;
            board_queue.delete();
        end else begin
            if (i_valid) begin
                if (board_queue.size() == 0) begin
                    $error("Result beat with no sample outstanding: %h", i_result);
                    mismatches++;
                end else begin
                    check_board_sample(board_queue.pop_front(), i_result);
                end
            end
            if (i_start && !i_busy) begin
                board_queue.push_back(board_sample(i_sample));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LOW_G_SCALE:  low_g_gain = i_cfg_data[SCALE_W-1:0];
                    CFG_HIGH_G_SCALE: high_g_gain = i_cfg_data[SCALE_W-1:0];
                    CFG_GYRO_SCALE:   gyro_gain = i_cfg_data[SCALE_W-1:0];
                    CFG_ROT_COS:      cos_q = i_cfg_data[TRIG_W-1:0];
                    CFG_ROT_SIN:      sin_q = i_cfg_data[TRIG_W-1:0];
                    CFG_BIAS_X:       offset_x = i_cfg_data[OUT_W-1:0];
                    CFG_BIAS_Y:       offset_y = i_cfg_data[OUT_W-1:0];
                    CFG_BIAS_Z:       offset_z = i_cfg_data[OUT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        o_pending <= board_queue.size();
        o_errors  <= mismatches;
    end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
    import isrb_pkg::*;

    localparam int N_REGS            = CFG_BIAS_Z + 1;
    localparam int N_SETTINGS        = 5;
    localparam int SAMPLES_PER_PHASE = 100;
    localparam logic signed [RAW_W-1:0] RAW_MAX = {1'b0, {(RAW_W - 1){1'b1}}};
    localparam logic signed [RAW_W-1:0] RAW_MIN = {1'b1, {(RAW_W - 1){1'b0}}};

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    t_sample              i_sample    = '0;
    logic                 o_valid;
    t_result              o_result;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;

    int                   pending;
    int                   errors;
    int                   sent        = 0;
    int                   idle_pct    = 28;
    logic [CFG_DAT_W-1:0] cfg_words [N_REGS];

    always #5 i_clk = ~i_clk;

    imu_scale_rotate_bias dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_sample    (i_sample),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    isrb_result_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_sample    (i_sample),
        .i_valid     (o_valid),
        .i_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    function automatic logic signed [RAW_W-1:0] pick_raw();
        case ($urandom_range(7))
            0: return RAW_MAX;
            1: return RAW_MIN;
            2: return '0;
            3: return '1;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    function automatic t_sample random_sample();
        t_sample s;
        s.stamp      = $urandom;
        s.lo_raw_x   = pick_raw();
        s.lo_raw_y   = pick_raw();
        s.lo_raw_z   = pick_raw();
        s.hi_raw_x   = pick_raw();
        s.hi_raw_y   = pick_raw();
        s.hi_raw_z   = pick_raw();
        s.rate_raw_x = pick_raw();
        s.rate_raw_y = pick_raw();
        s.rate_raw_z = pick_raw();
        return s;
    endfunction

    function automatic t_sample axis_sample(
        logic [STAMP_W-1:0] stamp,
        logic signed [RAW_W-1:0] x, y, z
    );
        t_sample s;
        s.stamp      = stamp;
        s.lo_raw_x   = x;
        s.lo_raw_y   = y;
        s.lo_raw_z   = z;
        s.hi_raw_x   = x;
        s.hi_raw_y   = y;
        s.hi_raw_z   = z;
        s.rate_raw_x = x;
        s.rate_raw_y = y;
        s.rate_raw_z = z;
        return s;
    endfunction

    function automatic logic [CFG_DAT_W-1:0] random_trig();
        int v;
        v = $urandom_range(131072);
        if ($urandom_range(1)) begin
            return CFG_DAT_W'(v - 65536);
        end
        return $urandom;
    endfunction

    task automatic send_sample(input t_sample s);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start    <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (busy);
        sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Writes to unused indexes come last so that a bad decode corrupts a live register.
    task automatic write_setting(input bit with_unused);
        for (int r = CFG_LOW_G_SCALE; r <= CFG_BIAS_Z; r++) begin
            write_reg(CFG_IDX_W'(r), cfg_words[r]);
        end
        if (with_unused) begin
            for (int r = N_REGS; r < 2 ** CFG_IDX_W; r++) begin
                write_reg(CFG_IDX_W'(r), $urandom);
            end
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        #2_000_000;
        $display("imu_scale_rotate_bias test failed");
        $finish;
    end

    initial begin
        int pause_at;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_sample(axis_sample(32'h0000_0000, '0, '0, '0));
        send_sample(axis_sample(32'hFFFF_FFFF, RAW_MAX, RAW_MAX, RAW_MAX));
        send_sample(axis_sample(32'h5555_5555, RAW_MIN, RAW_MIN, RAW_MIN));
        send_sample(axis_sample(32'hAAAA_AAAA, RAW_MAX, RAW_MIN, 16'sd1));
        send_sample(axis_sample(32'h8000_0001, RAW_MIN, RAW_MAX, -16'sd1));
        send_sample(axis_sample(32'h7FFF_FFFE, 16'sh5555, 16'shAAAA, 16'sh5555));
        send_sample(axis_sample(32'h0000_0001, 16'shAAAA, 16'sh5555, 16'shAAAA));
        send_sample(axis_sample(32'h1234_5678, 16'sd1, -16'sd1, '0));
        send_sample(axis_sample(32'h8765_4321, -16'sd1, 16'sd1, RAW_MAX));
        // With the reset factors, low-g counts of 8 and high-g counts of 128 land
        // exactly halfway between two output codes.
        send_sample(axis_sample(32'h0000_0008, 16'sd8, -16'sd8, 16'sd128));
        send_sample(axis_sample(32'h0000_0080, -16'sd128, 16'sd128, -16'sd8));
        send_sample(axis_sample(32'h0000_0100, 16'sd128, -16'sd128, 16'sd8));

        for (int setting = 1; setting <= N_SETTINGS; setting++) begin
            drain();
            case (setting)
                1: cfg_words = '{32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h5AFF_FFFF,
                                 32'hFFFF_0000, 32'h0001_0000,
                                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};
                2: cfg_words = '{32'h0000_0000, 32'hFF00_0000, 32'h00FF_FFFF,
                                 32'h0001_FFFF, 32'hFFFE_0000,
                                 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF};
                5: cfg_words = '{32'd80336, 32'd1285377, 32'd2048000,
                                 32'd65536, 32'd0, 32'd0, 32'd0, 32'd0};
                default: begin
                    cfg_words[CFG_LOW_G_SCALE]  = $urandom;
                    cfg_words[CFG_HIGH_G_SCALE] = $urandom;
                    cfg_words[CFG_GYRO_SCALE]   = $urandom;
                    cfg_words[CFG_ROT_COS]      = random_trig();
                    cfg_words[CFG_ROT_SIN]      = random_trig();
                    cfg_words[CFG_BIAS_X]       = $urandom;
                    cfg_words[CFG_BIAS_Y]       = $urandom;
                    cfg_words[CFG_BIAS_Z]       = $urandom;
                end
            endcase
            write_setting(setting == 1);
            pause_at = $urandom_range(20, 80);
            for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
                idle_pct = (sent < 180) ? 28 : (sent < 360) ? 79 : 0;
                if (n == pause_at) begin
                    drain();
                end
                send_sample(random_sample());
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        $display("Checked %0d samples under %0d register settings: reset, full and zero scale,",
                 sent, N_SETTINGS + 1);
        $display("rotation gains beyond unity, extreme biases, rounding ties and unused indexes.");
        if (errors == 0) begin
            $display("imu_scale_rotate_bias test passed");
        end else begin
            $display("imu_scale_rotate_bias test failed");
        end
        $finish;
    end

endmodule

>>> files.f
design/isrb_pkg.sv
design/imu_scale_rotate_bias.sv
design/isrb_checker.sv
test/isrb_result_checker.sv
test/tb.sv
